>>> design/slaq_pkg.sv
// ----------------------------------------------------------------------------
// slaq_pkg
// shared constants, codes and controller/datapath interface types for the
// serial line assembler queue
// ----------------------------------------------------------------------------
package slaq_pkg;

   // geometry of the line store
   localparam int LINE_BYTES  = 64;
   localparam int QUEUE_SLOTS = 4;
   localparam int MAX_CHARS   = LINE_BYTES - 1;
   localparam int IDX_W       = $clog2(LINE_BYTES);
   localparam int SLOT_W      = $clog2(QUEUE_SLOTS);
   localparam int ADDR_W      = SLOT_W + IDX_W;
   localparam int MEM_DEPTH   = QUEUE_SLOTS * LINE_BYTES;
   localparam int CNT_W       = 32;

   // special characters
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_NUL = 8'h00;

   // request opcodes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // response kinds
   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_CHAR  = 2'd1,
      KIND_EMPTY = 2'd2,
      KIND_NULL  = 2'd3
   } kind_type;

   // byte status codes
   typedef enum logic [2:0] {
      RS_STORED   = 3'd0,
      RS_QUEUED   = 3'd1,
      RS_DROPPED  = 3'd2,
      RS_OVERFLOW = 3'd3,
      RS_IGNORED  = 3'd4
   } status_type;

   // controller to datapath commands
   typedef struct packed {
      logic byte_take;
      logic pop_empty;
      logic pop_start;
      logic rd_issue;
      logic hold_load;
      logic emit_char;
      logic emit_last;
      logic emit_null;
   } ctl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic out_free;
      logic queue_empty;
      logic first_pos;
      logic last_hit;
   } dp_status_type;

endpackage

>>> design/slaq_ctrl.sv
// ----------------------------------------------------------------------------
// slaq_ctrl
// request sequencer: takes transactions and walks a popped line one
// character at a time
// ----------------------------------------------------------------------------
module slaq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_opcode,
   input  slaq_pkg::dp_status_type dp_status,
   output logic                    req_stall,
   output slaq_pkg::ctl_cmd_type   cmd
);
   import slaq_pkg::*;

   typedef enum logic [2:0] {
      FSM_IDLE  = 3'b001,
      FSM_READ  = 3'b010,
      FSM_CHECK = 3'b100
   } fsm_type;

   fsm_type state_ff;
   fsm_type state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         FSM_IDLE: begin
            req_stall = !dp_status.out_free;
            if (req_valid && dp_status.out_free) begin
               if (req_opcode == OP_BYTE) begin
                  cmd.byte_take = 1'b1;
               end else if (dp_status.queue_empty) begin
                  cmd.pop_empty = 1'b1;
               end else begin
                  cmd.pop_start = 1'b1;
                  state_in      = FSM_READ;
               end
            end
         end
         FSM_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = FSM_CHECK;
         end
         FSM_CHECK: begin
            // first character only primes the hold register
            if (dp_status.first_pos && !dp_status.last_hit) begin
               cmd.hold_load = 1'b1;
               state_in      = FSM_READ;
            end else if (dp_status.out_free) begin
               if (dp_status.first_pos) begin
                  cmd.emit_null = 1'b1;
                  state_in      = FSM_IDLE;
               end else begin
                  cmd.emit_char = 1'b1;
                  cmd.emit_last = dp_status.last_hit;
                  if (dp_status.last_hit) begin
                     state_in = FSM_IDLE;
                  end else begin
                     cmd.hold_load = 1'b1;
                     state_in      = FSM_READ;
                  end
               end
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/slaq_datapath.sv
// ----------------------------------------------------------------------------
// slaq_datapath
// line assembly state, ring pointers, counters, line store memory and the
// response register
// ----------------------------------------------------------------------------
module slaq_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              req_byte_value,
   input  slaq_pkg::ctl_cmd_type   cmd,
   input  logic                    rsp_stall,
   output slaq_pkg::dp_status_type dp_status,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_kind,
   output logic [2:0]              rsp_status,
   output logic [7:0]              rsp_out_char,
   output logic                    rsp_last,
   output logic [31:0]             rsp_lines_queued_total,
   output logic [31:0]             rsp_overflow_total,
   output logic [31:0]             rsp_drop_total,
   output logic [1:0]              rsp_queue_level
);
   import slaq_pkg::*;

   // assembly and ring state
   logic [IDX_W-1:0]  asm_len_ff, asm_len_in;
   logic              discard_ff, discard_in;
   logic [SLOT_W-1:0] wr_slot_ff, wr_slot_in;
   logic [SLOT_W-1:0] rd_slot_ff, rd_slot_in;
   logic [CNT_W-1:0]  queued_ff, queued_in;
   logic [CNT_W-1:0]  ovf_ff, ovf_in;
   logic [CNT_W-1:0]  drop_ff, drop_in;
   logic [IDX_W-1:0]  slot_len_ff [QUEUE_SLOTS];

   // pop walk
   logic [SLOT_W-1:0] pop_slot_ff;
   logic [IDX_W-1:0]  pop_len_ff;
   logic [IDX_W-1:0]  pos_ff;
   logic [7:0]        hold_ff;

   // line store, one row per slot, assembled in place at the write slot
   logic [7:0]        mem [MEM_DEPTH];
   logic [7:0]        rd_data_ff;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   kind_type          rsp_kind_ff, rsp_kind_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [7:0]        rsp_char_ff, rsp_char_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [CNT_W-1:0]  rsp_queued_ff, rsp_ovf_ff, rsp_drop_ff;
   logic [SLOT_W-1:0] rsp_level_ff, rsp_level_in;

   logic              is_term;
   logic              ring_full;
   logic [SLOT_W-1:0] next_wr;
   logic              mem_we;
   logic              slot_wr;
   logic              out_load;
   status_type        byte_status;

   assign is_term   = (req_byte_value == CH_CR) || (req_byte_value == CH_LF);
   assign next_wr   = wr_slot_ff + SLOT_W'(1);
   assign ring_full = (next_wr == rd_slot_ff);

   always_comb begin
      asm_len_in  = asm_len_ff;
      discard_in  = discard_ff;
      wr_slot_in  = wr_slot_ff;
      rd_slot_in  = rd_slot_ff;
      queued_in   = queued_ff;
      ovf_in      = ovf_ff;
      drop_in     = drop_ff;
      byte_status = RS_STORED;
      mem_we      = 1'b0;
      slot_wr     = 1'b0;
      if (cmd.byte_take) begin
         if (is_term) begin
            if (discard_ff) begin
               discard_in  = 1'b0;
               asm_len_in  = '0;
               byte_status = RS_IGNORED;
            end else if (asm_len_ff == '0) begin
               byte_status = RS_IGNORED;
            end else if (ring_full) begin
               drop_in     = drop_ff + CNT_W'(1);
               asm_len_in  = '0;
               byte_status = RS_DROPPED;
            end else begin
               slot_wr     = 1'b1;
               wr_slot_in  = next_wr;
               queued_in   = queued_ff + CNT_W'(1);
               asm_len_in  = '0;
               byte_status = RS_QUEUED;
            end
         end else if (discard_ff) begin
            byte_status = RS_OVERFLOW;
         end else if (asm_len_ff == IDX_W'(MAX_CHARS)) begin
            discard_in  = 1'b1;
            asm_len_in  = '0;
            ovf_in      = ovf_ff + CNT_W'(1);
            byte_status = RS_OVERFLOW;
         end else begin
            mem_we      = 1'b1;
            asm_len_in  = asm_len_ff + IDX_W'(1);
            byte_status = RS_STORED;
         end
      end
      if (cmd.pop_start) begin
         rd_slot_in = rd_slot_ff + SLOT_W'(1);
      end
   end

   // response assembly
   assign out_load = cmd.byte_take | cmd.pop_empty | cmd.emit_char | cmd.emit_null;

   always_comb begin
      if (cmd.byte_take) begin
         rsp_kind_in = KIND_BYTE;
      end else if (cmd.pop_empty) begin
         rsp_kind_in = KIND_EMPTY;
      end else if (cmd.emit_null) begin
         rsp_kind_in = KIND_NULL;
      end else begin
         rsp_kind_in = KIND_CHAR;
      end
      rsp_status_in = cmd.byte_take ? byte_status : RS_STORED;
      rsp_char_in   = cmd.emit_char ? hold_ff : CH_NUL;
      rsp_last_in   = cmd.emit_char ? cmd.emit_last : 1'b1;
      rsp_level_in  = wr_slot_in - rd_slot_in;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         asm_len_ff   <= '0;
         discard_ff   <= 1'b0;
         wr_slot_ff   <= '0;
         rd_slot_ff   <= '0;
         queued_ff    <= '0;
         ovf_ff       <= '0;
         drop_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         asm_len_ff   <= asm_len_in;
         discard_ff   <= discard_in;
         wr_slot_ff   <= wr_slot_in;
         rd_slot_ff   <= rd_slot_in;
         queued_ff    <= queued_in;
         ovf_ff       <= ovf_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (slot_wr) begin
         slot_len_ff[wr_slot_ff] <= asm_len_ff;
      end
      if (cmd.pop_start) begin
         pop_slot_ff <= rd_slot_ff;
         pop_len_ff  <= slot_len_ff[rd_slot_ff];
         pos_ff      <= '0;
      end else if (cmd.hold_load) begin
         hold_ff <= rd_data_ff;
         pos_ff  <= pos_ff + IDX_W'(1);
      end
      if (out_load) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_status_ff <= rsp_status_in;
         rsp_char_ff   <= rsp_char_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_queued_ff <= queued_in;
         rsp_ovf_ff    <= ovf_in;
         rsp_drop_ff   <= drop_in;
         rsp_level_ff  <= rsp_level_in;
      end
   end

   // line store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[{wr_slot_ff, asm_len_ff}] <= req_byte_value;
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= mem[{pop_slot_ff, pos_ff}];
      end
   end

   assign dp_status.out_free    = !rsp_valid_ff || !rsp_stall;
   assign dp_status.queue_empty = (wr_slot_ff == rd_slot_ff);
   assign dp_status.first_pos   = (pos_ff == '0);
   assign dp_status.last_hit    = (pos_ff == pop_len_ff) || (rd_data_ff == CH_NUL);

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_kind               = rsp_kind_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_out_char           = rsp_char_ff;
   assign rsp_last               = rsp_last_ff;
   assign rsp_lines_queued_total = rsp_queued_ff;
   assign rsp_overflow_total     = rsp_ovf_ff;
   assign rsp_drop_total         = rsp_drop_ff;
   assign rsp_queue_level        = 2'(rsp_level_ff);

endmodule

>>> design/serial_line_assembler_queue.sv
// ----------------------------------------------------------------------------
// serial_line_assembler_queue
// assembles received bytes into CR/LF terminated lines and queues finished
// lines in a small ring; pop transactions stream the oldest line back
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------
//   req     | in        | req_valid/req_stall  | opcode, byte_value
//   rsp     | out       | rsp_valid/rsp_stall  | kind, status, out_char, last,
//           |           |                      | three totals, queue_level
//
// a received byte or a pop of an empty queue gives one response
// a pop holds req_stall through its walk: a priming read, then per
// character a line store read and a check of the lookahead character
// that places the last mark
// reset is synchronous; a pop walk also reads the byte past its line's end
// a stalled response holds req_stall until taken and stretches a pop walk
//
module serial_line_assembler_queue (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [7:0]  req_byte_value,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_last,
   output logic [31:0] rsp_lines_queued_total,
   output logic [31:0] rsp_overflow_total,
   output logic [31:0] rsp_drop_total,
   output logic [1:0]  rsp_queue_level
);
   import slaq_pkg::*;

   // command and status between sequencer and datapath
   ctl_cmd_type   cmd;
   dp_status_type dp_status;

   // sequencer: accepts transactions, walks popped lines
   slaq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .dp_status  (dp_status),
      .req_stall  (req_stall),
      .cmd        (cmd)
   );

   // datapath: assembly, ring, counters, line store, response register
   slaq_datapath u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .req_byte_value         (req_byte_value),
      .cmd                    (cmd),
      .rsp_stall              (rsp_stall),
      .dp_status              (dp_status),
      .rsp_valid              (rsp_valid),
      .rsp_kind               (rsp_kind),
      .rsp_status             (rsp_status),
      .rsp_out_char           (rsp_out_char),
      .rsp_last               (rsp_last),
      .rsp_lines_queued_total (rsp_lines_queued_total),
      .rsp_overflow_total     (rsp_overflow_total),
      .rsp_drop_total         (rsp_drop_total),
      .rsp_queue_level        (rsp_queue_level)
   );

`ifndef SYNTHESIS
   // an accepted byte shows its status response in the next cycle
   a_byte_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_opcode == OP_BYTE)
      |=> (rsp_valid && rsp_kind == KIND_BYTE && rsp_last))
      else $error("byte transaction without status response");

   // only line characters may be non-final
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_CHAR) |-> rsp_last)
      else $error("single-result response without last mark");

   // status is zero outside byte responses
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_BYTE) |-> (rsp_status == RS_STORED))
      else $error("status set on non-byte response");

   // a started pop always fetches its first character next
   a_pop_fetch: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_start |=> (cmd.rd_issue && req_stall))
      else $error("pop started without line store read");
`endif

endmodule
